// ----- hdl/tsd_pkg.sv -----
// Shared constants, codes and types of the tach speed / PD motor drive block.
// No dependencies; used by the channel interfaces and the top level.
package tsd_pkg;

  // Channel count and timer width
  localparam int CHANNELS   = 4;
  localparam int TIMER_BITS = 8;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int CHAN_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int ELAP_W     = 24;
  localparam int SPEED_W    = 24;
  localparam int SLOPE_W    = 32;
  localparam int POS_W      = 24;
  localparam int SETP_W     = 15;
  localparam int DRIVE_W    = 8;
  localparam int CUT_W      = 16;
  localparam int NUM_W      = 24;

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Shared divider: 32-bit dividend, 24-bit divisor
  localparam int DIV_W      = 32;
  localparam int CNT_W      = $clog2(DIV_W);
  localparam int SPD_STEPS  = NUM_W;
  localparam int SLP_STEPS  = DIV_W;

  // Control accumulator: error * 512 minus slope
  localparam int ACC_W      = 36;
  localparam int GAIN_SHIFT = 9;
  localparam int DRV_SHIFT  = 4;

  // Reset values
  localparam logic [CUT_W-1:0]   CUTOFF_RST    = 16'd215;
  localparam logic [NUM_W-1:0]   NUMERATOR_RST = 24'd2142500;
  localparam logic [DRIVE_W-1:0] DRIVE_MIN_RST = 8'd63;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX_RST = 8'd156;
  localparam logic [POS_W-1:0]   POSITION_RST  = 24'd1000;
  localparam logic [SETP_W-1:0]  SETPOINT_RST  = 15'd900;
  localparam logic [SETP_W-1:0]  SETP_SCALE    = 15'd100;

  // Input actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_EDGE     = 2'd1,
    ACT_SETPOINT = 2'd2,
    ACT_CONTROL  = 2'd3
  } action_t;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF    = 2'd0,
    REG_NUMERATOR = 2'd1,
    REG_DRIVE_MIN = 2'd2,
    REG_DRIVE_MAX = 2'd3
  } reg_index_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_CHK,
    ST_DIV_SPD,
    ST_SPD_FIN,
    ST_DIV_SLP,
    ST_SLP_FIN,
    ST_CTL_SUB,
    ST_CTL_RND,
    ST_CTL_POS,
    ST_CTL_DRV,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/tsd_chan_if.sv -----
// Valid/ready channel interfaces: command words, result words, config writes.
// Depends on tsd_pkg for field widths.

interface tsd_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tsd_pkg::ACTION_W-1:0]  action;
  logic [tsd_pkg::CHAN_W-1:0]    channel;
  logic [tsd_pkg::BYTE_W-1:0]    timer_value;
  logic [tsd_pkg::BYTE_W-1:0]    setpoint_high;
  logic [tsd_pkg::BYTE_W-1:0]    setpoint_low;

  modport source (output valid, action, channel, timer_value, setpoint_high, setpoint_low,
                  input ready);
  modport sink   (input valid, action, channel, timer_value, setpoint_high, setpoint_low,
                  output ready);
endinterface

interface tsd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tsd_pkg::CHAN_W-1:0]    out_channel;
  logic                          edge_accepted;
  logic [tsd_pkg::SPEED_W-1:0]   speed;
  logic [tsd_pkg::DRIVE_W-1:0]   drive;

  modport source (output valid, out_channel, edge_accepted, speed, drive, input ready);
  modport sink   (input valid, out_channel, edge_accepted, speed, drive, output ready);
endinterface

interface tsd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tsd_pkg::CFG_IDX_W-1:0]  index;
  logic [tsd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/tach_speed_pd_motor_drive_unit.sv -----
// Top level of the four-channel tach speed meter and PD drive regulator.
// Depends on tsd_pkg and the channel interfaces in tsd_chan_if.sv.
//
// Usage:
//   cmd  : one command word per item (timer wrap tick, tach edge, setpoint
//          write, control step) addressed to a motor channel.
//   rsp  : exactly one result word per command: channel, edge flag, the
//          channel's speed and drive after the command.
//   cfg  : register writes (cutoff, speed numerator, drive min/max), always
//          ready; write only while no command is in flight.
// Timing: one command is worked on at a time; cmd.ready is high only while
//   the sequencer is idle. Tick and setpoint go from DECODE to DONE, a
//   rejected edge also passes EDGE_CHK, and a control step passes CTL_SUB,
//   CTL_RND, CTL_POS and CTL_DRV. An accepted tach edge costs most; the edge
//   cost is set by the shared restoring divider, which retires one quotient
//   bit per cycle: 24 steps for the speed and 32 for the Q8 slope.
// Stall: the result sits in an output register; a new command is taken
//   while it waits, and that command's result holds in the last state
//   until the register frees.
// Reset (rst, synchronous): registers return to their defaults, all channel
//   state clears (position 1000, setpoint 900), no result is pending.

module tach_speed_pd_motor_drive_unit (
  input  logic      clk,
  input  logic      rst,
  tsd_cmd_if.sink   cmd,
  tsd_rsp_if.source rsp,
  tsd_cfg_if.sink   cfg
);

  // Config registers
  logic [tsd_pkg::CUT_W-1:0]   cutoff_ticks;
  logic [tsd_pkg::NUM_W-1:0]   speed_numerator;
  logic [tsd_pkg::DRIVE_W-1:0] drive_min;
  logic [tsd_pkg::DRIVE_W-1:0] drive_max;

  // Per-channel state
  logic [tsd_pkg::ELAP_W-1:0]       elapsed_count  [tsd_pkg::CHANNELS];
  logic [tsd_pkg::TIMER_BITS-1:0]   edge_start     [tsd_pkg::CHANNELS];
  logic [tsd_pkg::SPEED_W-1:0]      speed_store    [tsd_pkg::CHANNELS];
  logic signed [tsd_pkg::SLOPE_W-1:0] slope_store  [tsd_pkg::CHANNELS];
  logic signed [tsd_pkg::POS_W-1:0] position_store [tsd_pkg::CHANNELS];
  logic [tsd_pkg::SETP_W-1:0]       setpoint_store [tsd_pkg::CHANNELS];
  logic [tsd_pkg::DRIVE_W-1:0]      drive_store    [tsd_pkg::CHANNELS];

  // Sequencer
  tsd_pkg::state_t state, state_next;

  // Latched command word
  tsd_pkg::action_t               act_r;
  logic [tsd_pkg::CHAN_W-1:0]     ch_r;
  logic [tsd_pkg::TIMER_BITS-1:0] tv_r;
  logic [tsd_pkg::BYTE_W-1:0]     sp_hi_r;
  logic [tsd_pkg::BYTE_W-1:0]     sp_lo_r;

  // Working registers
  logic [tsd_pkg::ELAP_W-1:0]        el_r;
  logic [tsd_pkg::SPEED_W-1:0]       sp_r;
  logic                              neg_r;
  logic [tsd_pkg::ELAP_W-1:0]        rem_r;
  logic [tsd_pkg::DIV_W-1:0]         dq_r;
  logic [tsd_pkg::CNT_W-1:0]         cnt_r;
  logic signed [tsd_pkg::ACC_W-1:0]  acc_r;
  logic signed [tsd_pkg::POS_W-1:0]  pos_r;
  logic                              edge_ok_r;

  // Result register
  logic                        out_valid;
  logic [tsd_pkg::CHAN_W-1:0]  out_chan;
  logic                        out_edge;
  logic [tsd_pkg::SPEED_W-1:0] out_speed;
  logic [tsd_pkg::DRIVE_W-1:0] out_drive;

  // Control strobes
  logic cmd_take;
  logic out_load;

  logic                         ch_ok;
  logic [tsd_pkg::CH_IDX_W-1:0] ci;

  assign ch_ok = (int'(ch_r) < tsd_pkg::CHANNELS);
  assign ci    = tsd_pkg::CH_IDX_W'(ch_r);

  // ---------------- config port ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_ticks    <= tsd_pkg::CUTOFF_RST;
      speed_numerator <= tsd_pkg::NUMERATOR_RST;
      drive_min       <= tsd_pkg::DRIVE_MIN_RST;
      drive_max       <= tsd_pkg::DRIVE_MAX_RST;
    end else if (cfg.valid) begin
      case (tsd_pkg::reg_index_t'(cfg.index))
        tsd_pkg::REG_CUTOFF:    cutoff_ticks    <= cfg.data[tsd_pkg::CUT_W-1:0];
        tsd_pkg::REG_NUMERATOR: speed_numerator <= cfg.data[tsd_pkg::NUM_W-1:0];
        tsd_pkg::REG_DRIVE_MIN: drive_min       <= cfg.data[tsd_pkg::DRIVE_W-1:0];
        tsd_pkg::REG_DRIVE_MAX: drive_max       <= cfg.data[tsd_pkg::DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- shared divider step ----------------
  // Restoring divide, one quotient bit per cycle; divisor is el_r.
  logic [tsd_pkg::ELAP_W:0]   rem_sh;
  logic [tsd_pkg::ELAP_W:0]   rem_trial;
  logic                       q_bit;
  logic [tsd_pkg::ELAP_W-1:0] rem_step;
  logic [tsd_pkg::DIV_W-1:0]  dq_step;

  always_comb begin
    rem_sh    = {rem_r, dq_r[tsd_pkg::DIV_W-1]};
    rem_trial = rem_sh - {1'b0, el_r};
    q_bit     = (rem_sh >= {1'b0, el_r});
    rem_step  = q_bit ? rem_trial[tsd_pkg::ELAP_W-1:0] : rem_sh[tsd_pkg::ELAP_W-1:0];
    dq_step   = {dq_r[tsd_pkg::DIV_W-2:0], q_bit};
  end

  // ---------------- elapsed at a tach edge ----------------
  // count + timer - start, clipped to [0, 2^24-1]
  logic [tsd_pkg::ELAP_W+1:0] e_sum;
  logic [tsd_pkg::ELAP_W-1:0] el_sat;

  always_comb begin
    e_sum = {2'b00, elapsed_count[ci]}
          + (tsd_pkg::ELAP_W+2)'(tv_r)
          - (tsd_pkg::ELAP_W+2)'(edge_start[ci]);
    if (e_sum[tsd_pkg::ELAP_W+1])     el_sat = '0;
    else if (e_sum[tsd_pkg::ELAP_W])  el_sat = '1;
    else                              el_sat = e_sum[tsd_pkg::ELAP_W-1:0];
  end

  // ---------------- timer wrap tick ----------------
  logic [tsd_pkg::ELAP_W:0]   tick_sum [tsd_pkg::CHANNELS];
  logic [tsd_pkg::ELAP_W-1:0] tick_sat [tsd_pkg::CHANNELS];

  always_comb begin
    for (int i = 0; i < tsd_pkg::CHANNELS; i++) begin
      tick_sum[i] = {1'b0, elapsed_count[i]}
                  + ((tsd_pkg::ELAP_W+1)'(1) << tsd_pkg::TIMER_BITS);
      tick_sat[i] = tick_sum[i][tsd_pkg::ELAP_W] ? '1 : tick_sum[i][tsd_pkg::ELAP_W-1:0];
    end
  end

  // ---------------- slope prep and finish ----------------
  logic [tsd_pkg::SPEED_W:0]         sp_diff;
  logic [tsd_pkg::SPEED_W:0]         sp_mag;
  logic [tsd_pkg::SLOPE_W-1:0]       slope_sat;
  localparam logic [tsd_pkg::SLOPE_W-1:0] SLOPE_MIN_MAG = {1'b1, {(tsd_pkg::SLOPE_W-1){1'b0}}};

  always_comb begin
    sp_diff = {1'b0, dq_r[tsd_pkg::SPEED_W-1:0]} - {1'b0, speed_store[ci]};
    sp_mag  = sp_diff[tsd_pkg::SPEED_W] ? (~sp_diff + 1'b1) : sp_diff;
    // quotient magnitude in dq_r; clip into signed 32 bits
    if (!neg_r) begin
      slope_sat = dq_r[tsd_pkg::DIV_W-1] ? ~SLOPE_MIN_MAG : dq_r;
    end else begin
      slope_sat = (dq_r > SLOPE_MIN_MAG) ? SLOPE_MIN_MAG : (~dq_r + 1'b1);
    end
  end

  // ---------------- control step arithmetic ----------------
  logic signed [tsd_pkg::ELAP_W+1:0] err;
  logic signed [tsd_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [tsd_pkg::ACC_W-1:0]  pos_sum;
  logic signed [tsd_pkg::POS_W-1:0]  pos_sat;
  logic signed [tsd_pkg::POS_W-1:0]  pos_rnd;
  logic signed [tsd_pkg::POS_W-1:0]  d_raw;
  logic signed [tsd_pkg::POS_W-1:0]  d_lo;
  logic signed [tsd_pkg::POS_W-1:0]  d_min_s;
  logic signed [tsd_pkg::POS_W-1:0]  d_max_s;
  logic [tsd_pkg::DRIVE_W-1:0]       drive_new;
  localparam logic signed [tsd_pkg::ACC_W-1:0] POS_HI = (tsd_pkg::ACC_W)'(8388607);
  localparam logic signed [tsd_pkg::ACC_W-1:0] POS_LO = -(tsd_pkg::ACC_W)'(8388608);

  always_comb begin
    err = $signed((tsd_pkg::ELAP_W+2)'(setpoint_store[ci]))
        - $signed({2'b00, speed_store[ci]});
    // truncate toward zero on the divide by 512
    acc_rnd = acc_r + (acc_r[tsd_pkg::ACC_W-1] ?
                       (tsd_pkg::ACC_W)'(511) : (tsd_pkg::ACC_W)'(0));
    pos_sum = {{(tsd_pkg::ACC_W-tsd_pkg::POS_W){position_store[ci][tsd_pkg::POS_W-1]}},
               position_store[ci]} + acc_r;
    if (pos_sum > POS_HI)      pos_sat = POS_HI[tsd_pkg::POS_W-1:0];
    else if (pos_sum < POS_LO) pos_sat = POS_LO[tsd_pkg::POS_W-1:0];
    else                       pos_sat = pos_sum[tsd_pkg::POS_W-1:0];
    // position / 16 toward zero, then clamp low, then high
    pos_rnd = pos_r + (pos_r[tsd_pkg::POS_W-1] ?
                       (tsd_pkg::POS_W)'(15) : (tsd_pkg::POS_W)'(0));
    d_raw   = pos_rnd >>> tsd_pkg::DRV_SHIFT;
    d_min_s = $signed((tsd_pkg::POS_W)'(drive_min));
    d_max_s = $signed((tsd_pkg::POS_W)'(drive_max));
    d_lo    = (d_raw < d_min_s) ? d_min_s : d_raw;
    drive_new = (d_lo > d_max_s) ? drive_max : d_lo[tsd_pkg::DRIVE_W-1:0];
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      tsd_pkg::ST_IDLE:     if (cmd.valid) state_next = tsd_pkg::ST_DECODE;
      tsd_pkg::ST_DECODE: begin
        if (act_r == tsd_pkg::ACT_EDGE && ch_ok)         state_next = tsd_pkg::ST_EDGE_CHK;
        else if (act_r == tsd_pkg::ACT_CONTROL && ch_ok) state_next = tsd_pkg::ST_CTL_SUB;
        else                                             state_next = tsd_pkg::ST_DONE;
      end
      tsd_pkg::ST_EDGE_CHK: begin
        if (el_r == '0 || el_r < tsd_pkg::ELAP_W'(cutoff_ticks))
          state_next = tsd_pkg::ST_DONE;
        else
          state_next = tsd_pkg::ST_DIV_SPD;
      end
      tsd_pkg::ST_DIV_SPD:  if (cnt_r == '0) state_next = tsd_pkg::ST_SPD_FIN;
      tsd_pkg::ST_SPD_FIN:  state_next = tsd_pkg::ST_DIV_SLP;
      tsd_pkg::ST_DIV_SLP:  if (cnt_r == '0) state_next = tsd_pkg::ST_SLP_FIN;
      tsd_pkg::ST_SLP_FIN:  state_next = tsd_pkg::ST_DONE;
      tsd_pkg::ST_CTL_SUB:  state_next = tsd_pkg::ST_CTL_RND;
      tsd_pkg::ST_CTL_RND:  state_next = tsd_pkg::ST_CTL_POS;
      tsd_pkg::ST_CTL_POS:  state_next = tsd_pkg::ST_CTL_DRV;
      tsd_pkg::ST_CTL_DRV:  state_next = tsd_pkg::ST_DONE;
      tsd_pkg::ST_DONE:     if (out_load) state_next = tsd_pkg::ST_IDLE;
      default:              state_next = tsd_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    cmd.ready = (state == tsd_pkg::ST_IDLE);
    cmd_take  = cmd.valid && (state == tsd_pkg::ST_IDLE);
    out_load  = (state == tsd_pkg::ST_DONE) && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tsd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // ---------------- command latch ----------------
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      act_r   <= tsd_pkg::action_t'(cmd.action);
      ch_r    <= cmd.channel;
      tv_r    <= tsd_pkg::TIMER_BITS'(cmd.timer_value);
      sp_hi_r <= cmd.setpoint_high;
      sp_lo_r <= cmd.setpoint_low;
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    case (state)
      tsd_pkg::ST_DECODE: begin
        edge_ok_r <= 1'b0;
        el_r      <= el_sat;
        acc_r     <= $signed((tsd_pkg::ACC_W)'(err)) <<< tsd_pkg::GAIN_SHIFT;
      end
      tsd_pkg::ST_EDGE_CHK: begin
        rem_r <= '0;
        dq_r  <= {speed_numerator, (tsd_pkg::DIV_W-tsd_pkg::NUM_W)'(0)};
        cnt_r <= tsd_pkg::CNT_W'(tsd_pkg::SPD_STEPS - 1);
      end
      tsd_pkg::ST_DIV_SPD, tsd_pkg::ST_DIV_SLP: begin
        rem_r <= rem_step;
        dq_r  <= dq_step;
        cnt_r <= cnt_r - 1'b1;
      end
      tsd_pkg::ST_SPD_FIN: begin
        sp_r  <= dq_r[tsd_pkg::SPEED_W-1:0];
        neg_r <= sp_diff[tsd_pkg::SPEED_W];
        rem_r <= '0;
        dq_r  <= {sp_mag[tsd_pkg::SPEED_W-1:0], (tsd_pkg::DIV_W-tsd_pkg::SPEED_W)'(0)};
        cnt_r <= tsd_pkg::CNT_W'(tsd_pkg::SLP_STEPS - 1);
      end
      tsd_pkg::ST_SLP_FIN: edge_ok_r <= 1'b1;
      tsd_pkg::ST_CTL_SUB: begin
        acc_r <= acc_r - {{(tsd_pkg::ACC_W-tsd_pkg::SLOPE_W){slope_store[ci][tsd_pkg::SLOPE_W-1]}},
                          slope_store[ci]};
      end
      tsd_pkg::ST_CTL_RND: acc_r <= acc_rnd >>> tsd_pkg::GAIN_SHIFT;
      tsd_pkg::ST_CTL_POS: pos_r <= pos_sat;
      default: ;
    endcase
  end

  // ---------------- channel state updates ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tsd_pkg::CHANNELS; i++) begin
        elapsed_count[i]  <= '0;
        edge_start[i]     <= '0;
        speed_store[i]    <= '0;
        slope_store[i]    <= '0;
        position_store[i] <= tsd_pkg::POSITION_RST;
        setpoint_store[i] <= tsd_pkg::SETPOINT_RST;
        drive_store[i]    <= '0;
      end
    end else begin
      case (state)
        tsd_pkg::ST_DECODE: begin
          if (act_r == tsd_pkg::ACT_TICK) begin
            for (int i = 0; i < tsd_pkg::CHANNELS; i++) elapsed_count[i] <= tick_sat[i];
          end else if (act_r == tsd_pkg::ACT_SETPOINT && ch_ok) begin
            setpoint_store[ci] <= tsd_pkg::SETP_W'(sp_hi_r) * tsd_pkg::SETP_SCALE
                                + tsd_pkg::SETP_W'(sp_lo_r);
          end
        end
        tsd_pkg::ST_SLP_FIN: begin
          speed_store[ci]   <= sp_r;
          slope_store[ci]   <= slope_sat;
          elapsed_count[ci] <= '0;
          edge_start[ci]    <= tv_r;
        end
        tsd_pkg::ST_CTL_POS: position_store[ci] <= pos_sat;
        tsd_pkg::ST_CTL_DRV: drive_store[ci]    <= drive_new;
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (out_load)     out_valid <= 1'b1;
    else if (rsp.ready)    out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan  <= ch_r;
      out_edge  <= edge_ok_r;
      out_speed <= ch_ok ? speed_store[ci] : '0;
      out_drive <= ch_ok ? drive_store[ci] : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.out_channel   = out_chan;
  assign rsp.edge_accepted = out_edge;
  assign rsp.speed         = out_speed;
  assign rsp.drive         = out_drive;

  // ---------------- assertions ----------------
  // Partial remainder stays below the divisor while dividing.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == tsd_pkg::ST_DIV_SPD || state == tsd_pkg::ST_DIV_SLP) |-> (rem_r < el_r))
    else $error("divider remainder not below divisor");

  // Edge flag is only ever reported for a tach edge command.
  a_edge_flag: assert property (@(posedge clk) disable iff (rst)
    (out_load && edge_ok_r) |-> (act_r == tsd_pkg::ACT_EDGE))
    else $error("edge flag set for a non-edge command");

  // With sane clamps the stored drive lands inside them.
  a_drive_clamp: assert property (@(posedge clk) disable iff (rst)
    (state == tsd_pkg::ST_CTL_DRV && drive_min <= drive_max) |=>
      (drive_store[ci] >= drive_min && drive_store[ci] <= drive_max))
    else $error("drive outside clamp range");

endmodule
